// ===== src/sct_pkg.sv =====
// Package for the socket connection table: sizes, command, status and state codes.
// No dependencies.
package sct_pkg;

    localparam int NumSlots = 16;
    localparam int SlotW    = (NumSlots > 1) ? $clog2(NumSlots) : 1;
    localparam int CntW     = $clog2(NumSlots + 1);

    typedef enum logic [2:0] {
        CMD_CREATE = 3'd0,
        CMD_BIND   = 3'd1,
        CMD_CONN   = 3'd2,
        CMD_LISTEN = 3'd3,
        CMD_CLOSE  = 3'd4,
        CMD_FIND   = 3'd5,
        CMD_FINDL  = 3'd6,
        CMD_NOP    = 3'd7
    } t_cmd;

    typedef enum logic [3:0] {
        RES_OK        = 4'd0,
        RES_BAD_TYPE  = 4'd1,
        RES_FULL      = 4'd2,
        RES_BAD_INDEX = 4'd3,
        RES_SLOT_FREE = 4'd4,
        RES_CONFLICT  = 4'd5,
        RES_NOT_STREAM = 4'd6,
        RES_NO_PORT   = 4'd7,
        RES_NOT_FOUND = 4'd8
    } t_res;

    localparam logic [1:0] ST_FREE   = 2'd0;
    localparam logic [1:0] ST_BOUND  = 2'd1;
    localparam logic [1:0] ST_LISTEN = 2'd2;
    localparam logic [1:0] ST_CONN   = 2'd3;

    localparam logic [1:0] TYPE_DGRAM  = 2'd1;
    localparam logic [1:0] TYPE_STREAM = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_EXEC = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

endpackage

// ===== src/socket_connection_table.sv =====
// Socket connection table top level: entry storage, scan sequencer and result register.
// Depends on sct_pkg.
//
// Usage:
//   Slave channel s_axis_* carries one command per request (packed fields in tdata);
//   master channel m_axis_* returns exactly one result per command.
//   Each command walks all NumSlots entries through one shared compare unit, one
//   entry per cycle, then performs its single write-back and raises the result.
//   After the result is taken the sequencer returns to idle, and only then is the
//   next command accepted: commands do not overlap. The entry scan over the table
//   sets how long a command takes.
//   Reset (i_rst_n low, synchronous) frees every entry at once through per-entry
//   state flip-flops and clears the live count; other entry fields are cleared
//   when a slot is claimed, so a free slot always reads as zero where it matters.
//   When the receiver stalls, the result holds in the output register and no
//   new command is accepted until it is taken.
module socket_connection_table (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cmd[2:0], sock_type[4:3], slot_index[12:5], host_addr[44:13], host_port[60:45],
    // peer_addr[92:61], peer_port[108:93], queue_limit[124:109], zero[127:125]
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[3:0], found_slot[11:4], used_count[20:12], zero[23:21]
    output logic [23:0]  m_axis_tdata
);

    localparam int N = sct_pkg::NumSlots;
    localparam int SW = sct_pkg::SlotW;
    localparam int CW = sct_pkg::CntW;

    // entry storage
    logic [1:0]  r_est [N];
    logic [1:0]  r_etyp [N];
    logic [31:0] r_elip [N];
    logic [15:0] r_elport [N];
    logic [31:0] r_erip [N];
    logic [15:0] r_erport [N];
    logic [15:0] r_eblog [N];
    logic [CW-1:0] r_live;

    sct_pkg::t_state r_state;
    logic [127:0] r_req;
    logic [SW:0]  r_k;
    logic         r_hit;
    logic [SW-1:0] r_hit_slot;
    logic [3:0]   r_status;
    logic [7:0]   r_slot;

    // request fields
    logic [2:0]  w_cmd;
    logic [1:0]  w_typ;
    logic [7:0]  w_idx;
    logic [31:0] w_lip, w_rip;
    logic [15:0] w_lport, w_rport, w_blog;
    assign w_cmd   = r_req[2:0];
    assign w_typ   = r_req[4:3];
    assign w_idx   = r_req[12:5];
    assign w_lip   = r_req[44:13];
    assign w_lport = r_req[60:45];
    assign w_rip   = r_req[92:61];
    assign w_rport = r_req[108:93];
    assign w_blog  = r_req[124:109];

    logic w_inr;
    logic [SW-1:0] w_is;
    assign w_inr = ({1'b0, w_idx} < 9'(N));
    assign w_is  = w_idx[SW-1:0];

    // shared compare unit: match of the scanned entry for the current command
    logic [SW-1:0] w_k;
    logic w_live_k, w_match;
    assign w_k = r_k[SW-1:0];
    assign w_live_k = (r_est[w_k] != sct_pkg::ST_FREE);
    always_comb begin
        case (sct_pkg::t_cmd'(w_cmd))
            sct_pkg::CMD_CREATE: w_match = !w_live_k;
            sct_pkg::CMD_BIND:   w_match = w_live_k && (w_k != w_is)
                                     && r_elport[w_k] == w_lport && r_elip[w_k] == w_lip;
            sct_pkg::CMD_FIND:   w_match = w_live_k && r_elport[w_k] == w_lport
                                     && r_elip[w_k] == w_lip && r_erport[w_k] == w_rport
                                     && r_erip[w_k] == w_rip;
            sct_pkg::CMD_FINDL:  w_match = r_est[w_k] == sct_pkg::ST_LISTEN
                                     && r_elport[w_k] == w_lport;
            default:             w_match = 1'b0;
        endcase
    end

    assign s_axis_tready = (r_state == sct_pkg::S_IDLE);
    assign m_axis_tvalid = (r_state == sct_pkg::S_OUT);
    assign m_axis_tdata  = {3'b0, 9'(r_live), r_slot, r_status};

    // sequencer, scan and write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sct_pkg::S_IDLE;
            r_live  <= '0;
            for (int i = 0; i < N; i++) r_est[i] <= sct_pkg::ST_FREE;
        end else begin
            case (r_state)
                sct_pkg::S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_req   <= s_axis_tdata;
                        r_k     <= '0;
                        r_hit   <= 1'b0;
                        r_state <= sct_pkg::S_SCAN;
                    end
                end
                sct_pkg::S_SCAN: begin
                    // keep the lowest matching slot
                    if (w_match && !r_hit) begin
                        r_hit      <= 1'b1;
                        r_hit_slot <= w_k;
                    end
                    if (r_k == (SW+1)'(N - 1)) r_state <= sct_pkg::S_EXEC;
                    r_k <= r_k + 1'b1;
                end
                sct_pkg::S_EXEC: begin
                    case (sct_pkg::t_cmd'(w_cmd))
                        sct_pkg::CMD_CREATE: begin
                            if (w_typ != sct_pkg::TYPE_DGRAM && w_typ != sct_pkg::TYPE_STREAM)
                            begin
                                r_status <= sct_pkg::RES_BAD_TYPE;
                                r_slot   <= '0;
                            end else if (!r_hit) begin
                                r_status <= sct_pkg::RES_FULL;
                                r_slot   <= '0;
                            end else begin
                                r_est[r_hit_slot]    <= sct_pkg::ST_BOUND;
                                r_etyp[r_hit_slot]   <= w_typ;
                                r_elip[r_hit_slot]   <= '0;
                                r_elport[r_hit_slot] <= '0;
                                r_erip[r_hit_slot]   <= '0;
                                r_erport[r_hit_slot] <= '0;
                                r_eblog[r_hit_slot]  <= '0;
                                r_live   <= r_live + 1'b1;
                                r_status <= sct_pkg::RES_OK;
                                r_slot   <= 8'(r_hit_slot);
                            end
                        end
                        sct_pkg::CMD_BIND: begin
                            r_slot <= '0;
                            if (!w_inr) r_status <= sct_pkg::RES_BAD_INDEX;
                            else if (r_est[w_is] == sct_pkg::ST_FREE)
                                r_status <= sct_pkg::RES_SLOT_FREE;
                            else if (r_hit) r_status <= sct_pkg::RES_CONFLICT;
                            else begin
                                r_status       <= sct_pkg::RES_OK;
                                r_elip[w_is]   <= w_lip;
                                r_elport[w_is] <= w_lport;
                            end
                        end
                        sct_pkg::CMD_CONN: begin
                            r_slot <= '0;
                            if (!w_inr) r_status <= sct_pkg::RES_BAD_INDEX;
                            else if (r_est[w_is] == sct_pkg::ST_FREE)
                                r_status <= sct_pkg::RES_SLOT_FREE;
                            else begin
                                r_status       <= sct_pkg::RES_OK;
                                r_erip[w_is]   <= w_rip;
                                r_erport[w_is] <= w_rport;
                                r_est[w_is]    <= sct_pkg::ST_CONN;
                            end
                        end
                        sct_pkg::CMD_LISTEN: begin
                            // a free entry reads as type none
                            r_slot <= '0;
                            if (!w_inr) r_status <= sct_pkg::RES_BAD_INDEX;
                            else if (r_est[w_is] == sct_pkg::ST_FREE
                                     || r_etyp[w_is] != sct_pkg::TYPE_STREAM)
                                r_status <= sct_pkg::RES_NOT_STREAM;
                            else if (r_elport[w_is] == 16'd0)
                                r_status <= sct_pkg::RES_NO_PORT;
                            else begin
                                r_status      <= sct_pkg::RES_OK;
                                r_est[w_is]   <= sct_pkg::ST_LISTEN;
                                r_eblog[w_is] <= w_blog;
                            end
                        end
                        sct_pkg::CMD_CLOSE: begin
                            r_status <= sct_pkg::RES_OK;
                            r_slot   <= '0;
                            if (w_inr && r_est[w_is] != sct_pkg::ST_FREE) begin
                                r_est[w_is] <= sct_pkg::ST_FREE;
                                if (r_live != '0) r_live <= r_live - 1'b1;
                            end
                        end
                        sct_pkg::CMD_FIND, sct_pkg::CMD_FINDL: begin
                            if (r_hit) begin
                                r_status <= sct_pkg::RES_OK;
                                r_slot   <= 8'(r_hit_slot);
                            end else begin
                                r_status <= sct_pkg::RES_NOT_FOUND;
                                r_slot   <= '0;
                            end
                        end
                        default: begin
                            r_status <= sct_pkg::RES_OK;
                            r_slot   <= '0;
                        end
                    endcase
                    r_state <= sct_pkg::S_OUT;
                end
                sct_pkg::S_OUT: begin
                    if (m_axis_tready) r_state <= sct_pkg::S_IDLE;
                end
                default: r_state <= sct_pkg::S_IDLE;
            endcase
        end
    end

    // assertions
    a_live_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CW'(N)) else $error("live count above table size");
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_slot_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_status != sct_pkg::RES_OK |-> r_slot == 8'd0)
        else $error("slot reported with error status");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule
